/* hdl/assert_macros.svh */
// Assertion macros for the pose integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define AST_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define AST_IMP(lbl, clk, rstn, a, c)
`define AST_NXT(lbl, clk, rstn, a, c)
`endif
`endif

/* hdl/upi_pkg.sv */
// ----------------------------------------------------------------------------
// upi_pkg
// Shared types, constants and CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package upi_pkg;
  localparam int CordicStepsDef = 16;
  localparam int CordicStepsMax = 24;
  localparam logic [0:0] CfgWheelOffset = 1'b0;
  localparam logic [0:0] CfgStepTime    = 1'b1;
  localparam logic signed [31:0] CordicGain = 32'sd652032874;
  localparam logic [15:0] TwoPiQ13 = 16'd51472;

  typedef struct packed {
    logic               first;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic [15:0]        start_heading;
    logic signed [15:0] speed;
    logic signed [15:0] turn;
  } req_t;

  function automatic logic [29:0] atan_at(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0: r = 30'd536870912;   5'd1: r = 30'd316933406;
        5'd2: r = 30'd167458907;   5'd3: r = 30'd85004756;
        5'd4: r = 30'd42667331;    5'd5: r = 30'd21354465;
        5'd6: r = 30'd10679838;    5'd7: r = 30'd5340245;
        5'd8: r = 30'd2670163;     5'd9: r = 30'd1335087;
        5'd10: r = 30'd667544;     5'd11: r = 30'd333772;
        5'd12: r = 30'd166886;     5'd13: r = 30'd83443;
        5'd14: r = 30'd41722;      5'd15: r = 30'd20861;
        5'd16: r = 30'd10430;      5'd17: r = 30'd5215;
        5'd18: r = 30'd2608;       5'd19: r = 30'd1304;
        5'd20: r = 30'd652;        5'd21: r = 30'd326;
        5'd22: r = 30'd163;        5'd23: r = 30'd81;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction
endpackage

/* hdl/upi_queue.sv */
// ----------------------------------------------------------------------------
// upi_queue
// Front end: two-entry request queue between the input port and the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module upi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  upi_pkg::req_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_take,
  output upi_pkg::req_t  rd_data
);
  import upi_pkg::*;
  req_t       mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_take && rd_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

  `AST_IMP(a_no_over, clk, rst_n, cnt_r == 2'd2, !push)
  `AST_NXT(a_cnt_hold, clk, rst_n, push && pop, cnt_r == $past(cnt_r))
  `AST_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_r != 2'd3)
endmodule

/* hdl/upi_engine.sv */
// ----------------------------------------------------------------------------
// upi_engine
// Back end: sequencer with iterative CORDIC, shared multiplier and pose state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module upi_engine #(
  parameter int CORDIC_STEPS = upi_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        wheel_offset,
  input  logic [15:0]        step_time,
  input  logic               req_valid,
  output logic               req_take,
  input  upi_pkg::req_t      req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic signed [23:0] out_vel_north,
  output logic signed [23:0] out_vel_east
);
  import upi_pkg::*;
  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_BW1 = 4'd1, S_CORD = 4'd2,
    S_M1 = 4'd3, S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6, S_VEL = 4'd7,
    S_P1 = 4'd8, S_P2 = 4'd9, S_BW0 = 4'd10, S_OUT = 4'd11;

  logic [3:0]         st_r, st_nxt;
  logic signed [31:0] pn_r, pe_r;
  logic [15:0]        ang_r;
  logic signed [15:0] v_r, w_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic [4:0]         i_r;
  logic signed [33:0] wt_r;
  logic signed [19:0] bw_r;
  logic signed [53:0] acc_r, pa_r;
  logic signed [23:0] vn_r, ve_r;
  logic signed [53:0] prod;
  logic signed [33:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [33:0] dx, dy;
  logic [29:0]        zz;
  logic signed [53:0] rnd;
  logic signed [23:0] vsat;
  logic signed [32:0] psum;
  logic signed [31:0] psat;
  logic               flip_c;
  logic signed [16:0] fa;

  assign req_take  = (st_r == S_IDLE) && req_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_pos_x = pn_r;
  assign out_pos_y = pe_r;
  assign out_heading = ang_r;
  assign out_vel_north = vn_r;
  assign out_vel_east  = ve_r;

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (st_r)
      S_BW0: begin mul_a = 34'(w_r); mul_b = 20'(TwoPiQ13); end
      S_BW1: begin mul_a = wt_r; mul_b = {4'b0, wheel_offset}; end
      S_M1: begin mul_a = x_r; mul_b = 20'(v_r); end
      S_M2: begin mul_a = y_r; mul_b = bw_r; end
      S_M3: begin mul_a = y_r; mul_b = 20'(v_r); end
      S_M4: begin mul_a = x_r; mul_b = bw_r; end
      S_P1: begin mul_a = 34'(vn_r); mul_b = {4'b0, step_time}; end
      S_P2: begin mul_a = 34'(ve_r); mul_b = {4'b0, step_time}; end
      default: ;
    endcase
  end
  assign prod = 54'(mul_a) * 54'(mul_b);

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign zz = atan_at(i_r);
  assign rnd = (acc_r + 54'sd536870912) >>> 30;
  assign vsat = (rnd > 54'sd8388607) ? 24'sh7FFFFF :
                (rnd < -54'sd8388608) ? 24'sh800000 : 24'(rnd);
  assign psum = (st_r == S_P1) ? 33'(pn_r) + 33'((prod + 54'sd2048) >>> 12)
                               : 33'(pe_r) + 33'((prod + 54'sd2048) >>> 12);
  assign psat = (psum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                (psum < -33'sh080000000) ? 32'sh80000000 : 32'(psum);
  assign flip_c = (ang_r >= 16'd16384) && (ang_r < 16'd49152);
  assign fa = flip_c ? $signed({~ang_r[15], ~ang_r[15], ang_r[14:0]})
                     : $signed({ang_r[15], ang_r});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (req_valid) st_nxt = req.first ? S_OUT : S_BW0;
      S_BW0: st_nxt = S_BW1;
      S_BW1: st_nxt = S_CORD;
      S_CORD: if (i_r == LastStep) st_nxt = S_M1;
      S_M1: st_nxt = S_M2;
      S_M2: st_nxt = S_M3;
      S_M3: st_nxt = S_M4;
      S_M4: st_nxt = S_VEL;
      S_VEL: st_nxt = S_P1;
      S_P1: st_nxt = S_P2;
      S_P2: st_nxt = S_OUT;
      S_OUT: if (!out_stall) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pn_r <= '0; pe_r <= '0; ang_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (req_valid) begin
          i_r <= '0;
          v_r <= req.speed; w_r <= req.turn;
          if (req.first) begin
            pn_r <= req.start_x; pe_r <= req.start_y; ang_r <= req.start_heading;
            vn_r <= '0; ve_r <= '0;
          end else begin
            ang_r <= ang_r + req.turn;
          end
        end
        S_BW0: wt_r <= prod[33:0];
        S_BW1: begin
          bw_r <= 20'((prod + 54'sd268435456) >>> 29);
          flip_r <= flip_c;
          x_r <= 34'(CordicGain); y_r <= '0;
          z_r <= 34'(fa) <<< 16;
        end
        S_CORD: begin
          i_r <= i_r + 5'd1;
          if (!z_r[33]) begin
            x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - 34'(zz);
          end else begin
            x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + 34'(zz);
          end
          if (i_r == LastStep && flip_r) begin
            x_r <= -(z_r[33] ? x_r + dx : x_r - dx);
            y_r <= -(z_r[33] ? y_r - dy : y_r + dy);
          end
        end
        S_M1: pa_r <= prod;
        S_M2: acc_r <= pa_r - prod;
        S_M3: begin vn_r <= vsat; pa_r <= prod; end
        S_M4: acc_r <= pa_r + prod;
        S_VEL: ve_r <= vsat;
        S_P1: pn_r <= psat;
        S_P2: pe_r <= psat;
        default: ;
      endcase
    end
  end

  `AST_NXT(a_take_leaves, clk, rst_n, req_take, st_r != S_IDLE)
  `AST_IMP(a_out_idle, clk, rst_n, out_valid, !req_take)
  `AST_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pn_r))
endmodule

/* hdl/unicycle_pose_integrator_core.sv */
// ----------------------------------------------------------------------------
// unicycle_pose_integrator_core
// Fixed-point dead reckoning: heading, CORDIC velocity, saturating position.
// ----------------------------------------------------------------------------
//  channel | ports                    | handshake
//  in      | in_first .. in_turn      | in_valid / in_stall
//  out     | out_pos_x .. out_vel_east| out_valid / out_stall
//  cfg     | cfg_we, cfg_index, data  | write enable
// Into an idle block, a first request goes straight from idle to the output
// state; others pass through BW0, BW1, the iterative CORDIC (one rotation
// per cycle), then the multiply, velocity and position states.
// rst_n is synchronous; pose resets to zero, offset 4096, step 3277.
// A stalled result holds the engine; the two-entry queue accepts until full.
`timescale 1ns / 1ps
module unicycle_pose_integrator_core #(
  parameter int CORDIC_STEPS = upi_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_first,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic [15:0]        in_start_heading,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_turn,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [15:0]        out_heading,
  output logic signed [23:0] out_vel_north,
  output logic signed [23:0] out_vel_east
);
  import upi_pkg::*;
  logic [15:0] wheel_offset_r, step_time_r;
  req_t        wr, rd;
  logic        q_valid, q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_offset_r <= 16'd4096; step_time_r <= 16'd3277;
    end else if (cfg_we) begin
      if (cfg_index == CfgWheelOffset) wheel_offset_r <= cfg_data;
      if (cfg_index == CfgStepTime) step_time_r <= cfg_data;
    end
  end

  assign wr = '{first: in_first, start_x: in_start_x, start_y: in_start_y,
                start_heading: in_start_heading, speed: in_speed, turn: in_turn};

  upi_queue u_q (.clk, .rst_n, .wr_valid(in_valid), .wr_stall(in_stall), .wr_data(wr),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(rd));

  upi_engine #(.CORDIC_STEPS(CORDIC_STEPS)) u_eng (.clk, .rst_n,
    .wheel_offset(wheel_offset_r), .step_time(step_time_r),
    .req_valid(q_valid), .req_take(q_take), .req(rd),
    .out_valid, .out_stall, .out_pos_x, .out_pos_y, .out_heading,
    .out_vel_north, .out_vel_east);
endmodule
